### rtl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; imported by ole_ctrl, ole_dp and ordered_list_engine.
package ole_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_INSERT_AT = 3'd1,
    ACT_FIND      = 3'd2,
    ACT_READ_AT   = 3'd3,
    ACT_REMOVE_ID = 3'd4,
    ACT_REMOVE_AT = 3'd5,
    ACT_POP_FRONT = 3'd6,
    ACT_SCAN_SET  = 3'd7
  } action_t;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_FAIL      = 2'd1;
  localparam logic [1:0]  ST_NOT_FOUND = 2'd2;

  localparam logic [15:0] NO_ID  = 16'hFFFF;
  localparam logic [7:0]  NO_POS = 8'hFF;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input fields
    logic search;  // register match flags of every cell and the selected read word
    logic exec;    // apply the action, register the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;    // the action being executed produces a result
  } sts_t;

endpackage

### rtl/ole_ctrl.sv
// Sequencer for the ordered list engine: idle, search, execute.
// Depends on ole_pkg (cmd_t, sts_t).
module ole_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output ole_pkg::cmd_t cmd,
  input  ole_pkg::sts_t sts,
  output logic          out_valid
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SRCH;
      end
      S_SRCH: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec & sts.emit;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.search = (state_r == S_SRCH);
  assign cmd.exec   = (state_r == S_EXEC);
  assign out_valid  = out_valid_r;

endmodule

### rtl/ole_dp.sv
// Datapath of the ordered list engine: chain of entry cells with parallel
// compare and shift, entry count, scan accumulator and result registers.
// Depends on ole_pkg.
module ole_dp #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ole_pkg::cmd_t cmd,
  output ole_pkg::sts_t sts,
  input  logic [2:0]    in_action,
  input  logic [15:0]   in_mon_id,
  input  logic [7:0]    in_position,
  input  logic          in_last_of_set,
  output logic [1:0]    out_status,
  output logic [15:0]   out_id_out,
  output logic [7:0]    out_position_out,
  output logic [6:0]    out_count
);
  import ole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // captured item
  action_t     act_r;
  logic [15:0] id_r;
  logic [7:0]  pos_r;
  logic        last_r;

  logic [15:0]       entries_r [DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  logic [DEPTH-1:0]  match_r, match_nxt;
  logic [DEPTH-1:0]  sel_nxt;
  logic [15:0]       rd_r, rd_nxt;

  logic        best_valid_r, best_valid_nxt;
  logic [15:0] best_id_r, best_id_nxt;
  logic [7:0]  best_pos_r, best_pos_nxt;

  logic [1:0]  status_r, status_nxt;
  logic [15:0] id_o_r, id_o_nxt;
  logic [7:0]  pos_o_r, pos_o_nxt;
  logic [6:0]  cnt_o_r;

  logic [8:0]  cnt9, pos9, ins_pos9, rm_pos9, cnt_after9;
  logic        do_ins, do_rm, emit;
  logic        found;
  logic [7:0]  fpos;

  assign cnt9 = 9'(count_r);
  assign pos9 = {1'b0, pos_r};

  // capture; pop_front is remove_at position 0
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      id_r   <= in_mon_id;
      pos_r  <= (in_action == ACT_POP_FRONT) ? 8'd0 : in_position;
      last_r <= in_last_of_set;
    end
  end

  // per-cell compare against id and position, OR-select read
  always_comb begin
    rd_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (entries_r[i] == id_r) && (9'(i) < cnt9);
      sel_nxt[i]   = (9'(i) == pos9);
      rd_nxt       = rd_nxt | (entries_r[i] & {16{sel_nxt[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_r <= match_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // first matching cell
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found = 1'b1;
        fpos  = 8'(i);
      end
    end
  end

  always_comb begin
    do_ins         = 1'b0;
    do_rm          = 1'b0;
    ins_pos9       = pos9;
    rm_pos9        = pos9;
    emit           = 1'b1;
    status_nxt     = ST_FAIL;
    id_o_nxt       = NO_ID;
    pos_o_nxt      = NO_POS;
    best_valid_nxt = best_valid_r;
    best_id_nxt    = best_id_r;
    best_pos_nxt   = best_pos_r;
    unique case (act_r)
      ACT_APPEND, ACT_INSERT_AT: begin
        if (act_r == ACT_APPEND) ins_pos9 = cnt9;
        if ((cnt9 < 9'(DEPTH)) && (ins_pos9 <= cnt9)) begin
          do_ins     = 1'b1;
          status_nxt = ST_OK;
          id_o_nxt   = '0;
          pos_o_nxt  = ins_pos9[7:0];
        end
      end
      ACT_FIND: begin
        if (found) begin
          status_nxt = ST_OK;
          id_o_nxt   = '0;
          pos_o_nxt  = fpos;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_READ_AT: begin
        if (pos9 < cnt9) begin
          status_nxt = ST_OK;
          id_o_nxt   = rd_r;
          pos_o_nxt  = pos_r;
        end
      end
      ACT_REMOVE_ID: begin
        if (found) begin
          do_rm      = 1'b1;
          rm_pos9    = {1'b0, fpos};
          status_nxt = ST_OK;
          id_o_nxt   = id_r;
          pos_o_nxt  = fpos;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE_AT, ACT_POP_FRONT: begin
        if (pos9 < cnt9) begin
          do_rm      = 1'b1;
          status_nxt = ST_OK;
          id_o_nxt   = rd_r;
          pos_o_nxt  = pos_r;
        end
      end
      ACT_SCAN_SET: begin
        if (found && (!best_valid_r || (fpos < best_pos_r))) begin
          best_valid_nxt = 1'b1;
          best_id_nxt    = id_r;
          best_pos_nxt   = fpos;
        end
        emit = last_r;
        if (best_valid_nxt) begin
          status_nxt = ST_OK;
          id_o_nxt   = best_id_nxt;
          pos_o_nxt  = best_pos_nxt;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
        if (last_r) begin
          best_valid_nxt = 1'b0;
          best_id_nxt    = NO_ID;
          best_pos_nxt   = NO_POS;
        end
      end
      default: emit = 1'b1;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins)     count_nxt = count_r + CW'(1);
    else if (do_rm) count_nxt = count_r - CW'(1);
  end
  assign cnt_after9 = 9'(count_nxt);

  assign sts.emit = emit;

  // cell chain: each cell sees only its two neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [15:0] prev_w, next_w, cell_nxt;
    logic [8:0]  idx9;
    assign idx9 = 9'(g);
    if (g == 0) begin : g_first
      assign prev_w = NO_ID;
    end else begin : g_prev
      assign prev_w = entries_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = NO_ID;
    end else begin : g_next
      assign next_w = entries_r[g+1];
    end

    always_comb begin
      cell_nxt = entries_r[g];
      if (do_ins) begin
        if (idx9 > ins_pos9)       cell_nxt = prev_w;
        else if (idx9 == ins_pos9) cell_nxt = id_r;
      end else if (do_rm) begin
        if (idx9 >= rm_pos9) cell_nxt = next_w;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        entries_r[g] <= NO_ID;
      end else if (cmd.exec) begin
        entries_r[g] <= cell_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      best_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      count_r      <= count_nxt;
      best_valid_r <= best_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      best_id_r  <= best_id_nxt;
      best_pos_r <= best_pos_nxt;
      status_r   <= status_nxt;
      id_o_r     <= id_o_nxt;
      pos_o_r    <= pos_o_nxt;
      cnt_o_r    <= cnt_after9[6:0];
    end
  end

  assign out_status       = status_r;
  assign out_id_out       = id_o_r;
  assign out_position_out = pos_o_r;
  assign out_count        = cnt_o_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    9'(count_r) <= 9'(DEPTH))
    else $error("entry count beyond depth");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.exec)) |-> (count_r == $past(count_r)))
    else $error("entry count moved outside execute");

  a_emit_non_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (act_r != ACT_SCAN_SET)) |-> sts.emit)
    else $error("non-scan action without a result");
`endif

endmodule

### rtl/ordered_list_engine.sv
// Top level of the ordered list engine: controller plus cell-chain datapath.
// Depends on ole_pkg, ole_ctrl, ole_dp.
//
//  channel | ports                                          | transfer
//  --------+------------------------------------------------+-----------------------
//  input   | in_action in_mon_id in_position in_last_of_set | start & !busy
//  result  | out_status out_id_out out_position_out out_count| out_valid, one cycle
//
// Each action goes through capture, parallel compare of all cells
// (registered match flags and read word), then execute (shift of the cell chain,
// count and accumulator update, result registered). The strobe comes in
// the cycle after execute, in which busy is already low.
// Reset (rst_n low, synchronous) sets all cells to 0xFFFF, count to zero
// and empties the scan accumulator; no clearing pass is needed.
// The receiver cannot stall; a scan item that is not the last of its set
// gives no strobe.
module ordered_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_mon_id,
  input  logic [7:0]  in_position,
  input  logic        in_last_of_set,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_id_out,
  output logic [7:0]  out_position_out,
  output logic [6:0]  out_count
);
  import ole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns busy and the result strobe
  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid)
  );

  // list storage, compare and shift logic, result registers
  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_mon_id        (in_mon_id),
    .in_position      (in_position),
    .in_last_of_set   (in_last_of_set),
    .out_status       (out_status),
    .out_id_out       (out_id_out),
    .out_position_out (out_position_out),
    .out_count        (out_count)
  );

endmodule

### verif/tb_ordered_list_engine.sv
// Self-checking testbench for ordered_list_engine: directed corner actions, then
// randomized fill/drain/scan traffic checked against a behavioral list mirror.
// Depends on ole_pkg and the ordered_list_engine RTL.
`timescale 1ns / 1ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int TOTAL_ITEMS  = 1850;  // directed plus random
  localparam int POOL_SIZE    = 12;
  localparam int TAIL_CYCLES  = 12;    // strobe comes in the cycle after execute

  // One queued action as the driver presents it.
  typedef struct {
    action_t     act;
    logic [15:0] id;
    logic [7:0]  pos;
    logic        last;
    bit          drain;  // hold off until every answer is back
  } list_action_t;

  // One answer of the block.
  typedef struct {
    logic [1:0]  status;
    logic [15:0] id;
    logic [7:0]  pos;
    logic [6:0]  count;
  } list_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_action = ACT_APPEND;
  logic [15:0] in_mon_id = 16'h0000;
  logic [7:0]  in_position = 8'h00;
  logic        in_last_of_set = 1'b0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_id_out;
  logic [7:0]  out_position_out;
  logic [6:0]  out_count;

  ordered_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_mon_id        (in_mon_id),
    .in_position      (in_position),
    .in_last_of_set   (in_last_of_set),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_id_out       (out_id_out),
    .out_position_out (out_position_out),
    .out_count        (out_count)
  );

  always #5 clk = ~clk;

  list_action_t action_q[$];   // actions not yet presented
  list_answer_t answer_q[$];   // predicted answers, oldest first
  int           error_count = 0;
  logic         taken = 1'b0;  // an input transfer happened at the last rising edge

  // ---------------------------------------------------------------------
  // List mirror: the predicted contents of the cell chain and the scan
  // accumulator, updated once per accepted action.
  // ---------------------------------------------------------------------
  logic [15:0] mirror_ids [LIST_DEPTH];
  int          mirror_len;
  bit          scan_hit;
  logic [15:0] scan_id;
  int          scan_pos;

  // First slot holding id, LIST_DEPTH when absent.
  function automatic int mirror_locate(logic [15:0] id);
    for (int i = 0; i < mirror_len; i++)
      if (mirror_ids[i] == id) return i;
    return LIST_DEPTH;
  endfunction

  // Remove one slot; later entries move up, the freed tail slot reads NO_ID.
  function automatic logic [15:0] mirror_take(int slot);
    logic [15:0] id;
    id = mirror_ids[slot];
    mirror_len--;
    for (int i = slot; i < mirror_len; i++) mirror_ids[i] = mirror_ids[i + 1];
    mirror_ids[mirror_len] = NO_ID;
    return id;
  endfunction

  task automatic mirror_apply(input action_t act, input logic [15:0] id,
                              input logic [7:0] pos_in, input logic last,
                              output bit emits, output list_answer_t ans);
    int slot;
    int p;
    slot       = pos_in;
    emits      = 1'b1;
    ans.status = ST_FAIL;
    ans.id     = NO_ID;
    ans.pos    = NO_POS;
    case (act)
      ACT_APPEND, ACT_INSERT_AT: begin
        if (act == ACT_APPEND) slot = mirror_len;
        // full list or a position past the end is refused
        if (mirror_len < LIST_DEPTH && slot <= mirror_len) begin
          for (int i = mirror_len; i > slot; i--) mirror_ids[i] = mirror_ids[i - 1];
          mirror_ids[slot] = id;
          mirror_len++;
          ans.status = ST_OK;
          ans.id     = 16'h0000;
          ans.pos    = slot[7:0];
        end
      end
      ACT_FIND: begin
        p = mirror_locate(id);
        if (p < LIST_DEPTH) begin
          ans.status = ST_OK;
          ans.id     = 16'h0000;
          ans.pos    = p[7:0];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      ACT_READ_AT: begin
        if (slot < mirror_len) begin
          ans.status = ST_OK;
          ans.id     = mirror_ids[slot];
          ans.pos    = slot[7:0];
        end
      end
      ACT_REMOVE_ID: begin
        p = mirror_locate(id);
        if (p < LIST_DEPTH) begin
          ans.status = ST_OK;
          ans.id     = mirror_take(p);
          ans.pos    = p[7:0];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE_AT, ACT_POP_FRONT: begin
        if (act == ACT_POP_FRONT) slot = 0;
        if (slot < mirror_len) begin
          ans.status = ST_OK;
          ans.id     = mirror_take(slot);
          ans.pos    = slot[7:0];
        end
      end
      default: begin
        // scan: absent ids are skipped, strict compare keeps the first listed
        p = mirror_locate(id);
        if (p < LIST_DEPTH && (!scan_hit || p < scan_pos)) begin
          scan_hit = 1'b1;
          scan_id  = id;
          scan_pos = p;
        end
        if (!last) begin
          emits = 1'b0;
        end else begin
          if (scan_hit) begin
            ans.status = ST_OK;
            ans.id     = scan_id;
            ans.pos    = scan_pos[7:0];
          end else begin
            ans.status = ST_NOT_FOUND;
          end
          scan_hit = 1'b0;
          scan_id  = NO_ID;
          scan_pos = NO_POS;
        end
      end
    endcase
    ans.count = mirror_len[6:0];
  endtask

  // ---------------------------------------------------------------------
  // Input side: detect transfers at the rising edge and predict from the
  // values actually on the ports.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bit           emits;
    list_answer_t ans;
    if (!rst_n) begin
      for (int i = 0; i < LIST_DEPTH; i++) mirror_ids[i] = NO_ID;
      mirror_len = 0;
      scan_hit   = 1'b0;
      scan_id    = NO_ID;
      scan_pos   = NO_POS;
      taken     <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        mirror_apply(action_t'(in_action), in_mon_id, in_position, in_last_of_set,
                     emits, ans);
        if (emits) answer_q.push_back(ans);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: changes inputs at the falling edge. Works in bursts separated
  // by random gaps; start stays high across back-to-back transfers.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    list_action_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (action_q.size() == 0) begin
        start <= 1'b0;
      end else if (action_q[0].drain && (answer_q.size() != 0 || busy)) begin
        // pressure point: let the pipe run dry first
        start <= 1'b0;
      end else begin
        it = action_q.pop_front();
        in_action      <= it.act;
        in_mon_id      <= it.id;
        in_position    <= it.pos;
        in_last_of_set <= it.last;
        start          <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          // mostly short bursts, now and then a long unbroken stretch
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap_left   = $urandom_range(1, 9);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe is one result transfer, checked against the
  // oldest prediction field by field.
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] exp, logic [15:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s expected %h, actual %h", $time, name, exp, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    list_answer_t ans;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %h id %h pos %h",
                 $time, out_status, out_id_out, out_position_out);
        error_count++;
      end else begin
        ans = answer_q.pop_front();
        check_field("status", 16'(ans.status), 16'(out_status));
        check_field("id_out", ans.id, out_id_out);
        check_field("position_out", 16'(ans.pos), 16'(out_position_out));
        check_field("count", 16'(ans.count), 16'(out_count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  logic [15:0] id_pool [POOL_SIZE];
  int          est_len = 0;     // rough length estimate, steers positions
  bit          drain_next = 1'b0;

  task automatic queue_action(action_t act, logic [15:0] id, logic [7:0] pos, logic last);
    list_action_t it;
    it.act   = act;
    it.id    = id;
    it.pos   = pos;
    it.last  = last;
    it.drain = drain_next;
    drain_next = 1'b0;
    action_q.push_back(it);
    case (act)
      ACT_APPEND, ACT_INSERT_AT: if (est_len < LIST_DEPTH) est_len++;
      ACT_REMOVE_ID, ACT_REMOVE_AT, ACT_POP_FRONT: if (est_len > 0) est_len--;
      default: ;
    endcase
  endtask

  // Pool ids dominate so finds, removes and scans mostly hit.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  // Positions cluster around the valid range and its edge.
  function automatic logic [7:0] pick_pos(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'($urandom_range(0, 255));
    if (r < 35) return 8'((limit > 255) ? 255 : limit);
    return 8'($urandom_range(0, (limit > 255) ? 255 : limit));
  endfunction

  function automatic action_t pick_action(int mode);
    int wts [4][8] = '{'{40, 35, 5, 5, 4, 4, 2, 5},     // fill
                       '{8, 7, 10, 10, 25, 20, 12, 8},  // drain
                       '{15, 15, 12, 12, 12, 12, 7, 15},// mixed
                       '{10, 10, 5, 5, 5, 5, 5, 55}};   // scan heavy
    int r;
    r = $urandom_range(0, 99);
    for (int a = 0; a < 8; a++) begin
      if (r < wts[mode][a]) return action_t'(a);
      r -= wts[mode][a];
    end
    return ACT_SCAN_SET;
  endfunction

  task automatic queue_plain(action_t act);
    case (act)
      ACT_INSERT_AT: queue_action(act, pick_id(), pick_pos(est_len), 1'b0);
      ACT_READ_AT, ACT_REMOVE_AT: queue_action(act, pick_id(), pick_pos(est_len - 1), 1'b0);
      default: queue_action(act, pick_id(), 8'($urandom), 1'($urandom));
    endcase
  endtask

  // A scan set of one to five ids; sometimes other actions interleave and
  // sometimes the set is left open so it runs on into the next one.
  task automatic queue_scan_set();
    int  n;
    bit  open_set;
    action_t other;
    n        = $urandom_range(1, 5);
    open_set = ($urandom_range(0, 19) == 0);
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        other = action_t'($urandom_range(0, 6));
        queue_plain(other);
      end
      queue_action(ACT_SCAN_SET, pick_id(), 8'($urandom), (k == n - 1) && !open_set);
    end
  endtask

  task automatic build_directed();
    // empty-list refusals
    queue_action(ACT_POP_FRONT, 16'h0000, 8'h00, 1'b0);
    queue_action(ACT_REMOVE_AT, 16'h0000, 8'h00, 1'b0);
    queue_action(ACT_READ_AT,   16'h0000, 8'h00, 1'b1);
    queue_action(ACT_FIND,      16'h1234, 8'h00, 1'b0);
    queue_action(ACT_REMOVE_ID, 16'h1234, 8'hFF, 1'b0);
    queue_action(ACT_SCAN_SET,  16'h1234, 8'h00, 1'b1);  // nothing listed present
    // id extremes, insert at the front and at the end
    queue_action(ACT_APPEND,    16'h0000, 8'hFF, 1'b0);
    queue_action(ACT_APPEND,    16'hFFFF, 8'h00, 1'b0);
    queue_action(ACT_INSERT_AT, 16'h1234, 8'h00, 1'b0);
    queue_action(ACT_INSERT_AT, 16'hA5A5, 8'h03, 1'b0);  // position equal to count
    queue_action(ACT_INSERT_AT, 16'h5A5A, 8'h05, 1'b0);  // past the end
    queue_action(ACT_INSERT_AT, 16'h5A5A, 8'hFF, 1'b0);
    queue_action(ACT_FIND,      16'hFFFF, 8'h00, 1'b0);
    queue_action(ACT_READ_AT,   16'h0000, 8'h03, 1'b0);
    queue_action(ACT_READ_AT,   16'h0000, 8'hFF, 1'b0);
    // scan: absent id skipped, other action mid-set, repeated id, front wins
    queue_action(ACT_SCAN_SET,  16'h7777, 8'h00, 1'b0);
    queue_action(ACT_SCAN_SET,  16'hA5A5, 8'h00, 1'b0);
    queue_action(ACT_SCAN_SET,  16'h0000, 8'h00, 1'b0);
    queue_action(ACT_FIND,      16'hA5A5, 8'h00, 1'b0);
    queue_action(ACT_SCAN_SET,  16'h0000, 8'h00, 1'b0);
    queue_action(ACT_SCAN_SET,  16'h1234, 8'hFF, 1'b1);
    // shrinking
    queue_action(ACT_REMOVE_ID, 16'hFFFF, 8'h00, 1'b0);
    queue_action(ACT_REMOVE_AT, 16'h0000, 8'h00, 1'b0);
    queue_action(ACT_POP_FRONT, 16'h0000, 8'h00, 1'b0);
    queue_action(ACT_REMOVE_AT, 16'h0000, 8'h01, 1'b0);  // at count: refused
  endtask

  initial begin
    int mode;
    int seg_len;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = NO_ID;

    build_directed();
    drain_next = 1'b1;

    // fill to the limit, then knock on the full list
    repeat (LIST_DEPTH + 2) queue_action(ACT_APPEND, pick_id(), 8'($urandom), 1'b0);
    queue_action(ACT_INSERT_AT, pick_id(), 8'h0A, 1'b0);
    queue_action(ACT_INSERT_AT, pick_id(), 8'h40, 1'b0);
    est_len = LIST_DEPTH;

    while (action_q.size() < TOTAL_ITEMS) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(30, 120);
      // a segment stops early once the item budget is reached
      for (int s = 0; s < seg_len && action_q.size() < TOTAL_ITEMS; s++) begin
        if (pick_action(mode) == ACT_SCAN_SET) queue_scan_set();
        else queue_plain(pick_action(mode));
      end
      if ($urandom_range(0, 3) == 0) drain_next = 1'b1;
    end
    // close any open scan set so the run ends on a result
    queue_action(ACT_SCAN_SET, pick_id(), 8'h00, 1'b1);
  end

  // ---------------------------------------------------------------------
  // Reset, end of run and watchdog
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (action_q.size() != 0 || start) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d answers outstanding", answer_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
